### hdl/r5spw_pkg.sv
// Package for the RAID-5 stripe parity writer.
// Geometry constants, derived widths, rotation reciprocal and FSM type.
// No dependencies.
package r5spw_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int DRIVES      = 5;
    localparam int DATA_BYTES  = (DRIVES - 1) * BLOCK_BYTES;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int STRIPE_W    = 16;
    localparam int DRV_FIELD_W = 3;
    localparam int OFF_FIELD_W = 3;

    // internal widths
    localparam int OFF_W   = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int POS_W   = $clog2(DATA_BYTES);
    localparam int FILL_W  = $clog2(DATA_BYTES + 1);
    localparam int DRIVE_W = $clog2(DRIVES);

    // stripe mod DRIVES by reciprocal multiplication
    localparam int ROT_SH    = 19;
    localparam int ROT_RCP_W = 20;
    localparam int ROT_PROD_W = STRIPE_W + ROT_RCP_W;
    localparam logic [ROT_RCP_W-1:0] ROT_RCP =
        ROT_RCP_W'(((1 << ROT_SH) + DRIVES - 1) / DRIVES);

    typedef enum logic [5:0] {
        S_FILL  = 6'b000001,
        S_WB    = 6'b000010,
        S_QUOT  = 6'b000100,
        S_ROT   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

endpackage

### hdl/r5spw_in_if.sv
// Input channel of the stripe parity writer: one stream byte per transaction.
// Depends on r5spw_pkg.
interface r5spw_in_if import r5spw_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_data;

    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

### hdl/r5spw_out_if.sv
// Output channel of the stripe parity writer: one drive byte per transaction.
// Depends on r5spw_pkg.
interface r5spw_out_if import r5spw_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [DRV_FIELD_W-1:0] drive_index;
    logic [STRIPE_W-1:0]    stripe_number;
    logic [OFF_FIELD_W-1:0] byte_offset;
    logic [BYTE_W-1:0]      out_byte;
    logic                   is_parity;
    logic                   run_last;

    modport source (output valid, drive_index, stripe_number, byte_offset, out_byte,
                    is_parity, run_last, input ready);
    modport sink   (input valid, drive_index, stripe_number, byte_offset, out_byte,
                    is_parity, run_last, output ready);
endinterface

### hdl/r5spw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module r5spw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/raid5_stripe_parity_writer.sv
// Top level of the RAID-5 stripe parity writer (left-asymmetric parity).
// Depends on r5spw_pkg, r5spw_in_if, r5spw_out_if and r5spw_ram.
//
// Usage:
//  - i_in carries stream bytes; end_of_data marks the last byte and closes a
//    partial stripe. o_out carries one drive byte per transaction.
//  - i_cfg_we / i_cfg_wdata write first_stripe, the number of the first
//    stripe; write it only while the block is idle.
//  - While a stripe fills, one byte is taken per cycle (ready high). Data
//    goes to the stripe buffer RAM, parity is read-modify-written in the
//    parity RAM, with forwarding between back-to-back updates.
//  - The byte that completes a stripe (or carries end_of_data) starts a
//    flush: ready drops, the S_WB, S_QUOT and S_ROT states do write-back and
//    parity-rotation work, then DRIVES*BLOCK_BYTES bytes leave at one per
//    cycle while o_out is not stalled, drive by drive.
//  - Emitting one drive byte per cycle sets the pace; no new stream byte
//    is taken until the flush ends.
//  - Stalls on o_out hold the pipeline without loss; the output register
//    decouples the receiver, and ready returns once the last read drains.
//  - Synchronous reset clears counters, parity valid bits and first_stripe;
//    no clearing pass is needed.
module raid5_stripe_parity_writer import r5spw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    r5spw_in_if.sink            i_in,
    r5spw_out_if.source         o_out,
    input  logic                i_cfg_we,
    input  logic [STRIPE_W-1:0] i_cfg_wdata
);
    t_state r_state, n_state;

    logic [STRIPE_W-1:0]    r_first, r_cnt, r_stripe, r_q;
    logic [DRIVE_W-1:0]     r_pdrive;
    logic [FILL_W-1:0]      r_fill;
    logic [OFF_W-1:0]       r_poff;
    logic [BLOCK_BYTES-1:0] r_pvalid;

    logic                   r_wb_v, r_fwd;
    logic [OFF_W-1:0]       r_wb_addr;
    logic [BYTE_W-1:0]      r_wb_byte, r_fwd_data;

    logic [DRIVE_W-1:0]     r_d;
    logic [OFF_W-1:0]       r_b;
    logic [FILL_W-1:0]      r_pos;

    logic                   r_s1_v, r_s1_par, r_s1_last, r_s1_zero;
    logic [DRIVE_W-1:0]     r_s1_drive;
    logic [OFF_W-1:0]       r_s1_off;

    logic                   r_o_v, r_o_par, r_o_last;
    logic [DRIVE_W-1:0]     r_o_drive;
    logic [OFF_W-1:0]       r_o_off;
    logic [BYTE_W-1:0]      r_o_byte;
    logic [STRIPE_W-1:0]    r_o_stripe;

    logic                   accept, flush_now, advance, issue, is_par, last_issue;
    logic [FILL_W-1:0]      fill_inc;
    logic [BYTE_W-1:0]      p_rdata, b_rdata, p_old, pw_data;
    logic                   p_re, b_re;
    logic [OFF_W-1:0]       p_raddr;
    logic [ROT_PROD_W-1:0]  rot_prod;
    logic [STRIPE_W-1:0]    rot_rem0, rot_rem;

    assign i_in.ready = (r_state == S_FILL);
    assign accept     = i_in.valid && i_in.ready;
    assign fill_inc   = r_fill + FILL_W'(1);
    assign flush_now  = accept && (i_in.end_of_data || fill_inc == FILL_W'(DATA_BYTES));

    assign advance    = !r_o_v || o_out.ready;
    assign issue      = (r_state == S_EMIT) && (!r_s1_v || advance);
    assign is_par     = (r_d == r_pdrive);
    assign last_issue = (r_d == DRIVE_W'(DRIVES - 1)) && (r_b == OFF_W'(BLOCK_BYTES - 1));

    // parity read-modify-write
    assign p_old   = r_fwd ? r_fwd_data : (r_pvalid[r_wb_addr] ? p_rdata : '0);
    assign pw_data = p_old ^ r_wb_byte;
    assign p_re    = accept || (issue && is_par);
    assign p_raddr = accept ? r_poff : r_b;
    assign b_re    = issue && !is_par;

    // stripe mod DRIVES
    assign rot_prod = ROT_PROD_W'(r_stripe) * ROT_PROD_W'(ROT_RCP);
    assign rot_rem0 = r_stripe - STRIPE_W'(r_q * STRIPE_W'(DRIVES));
    assign rot_rem  = (rot_rem0 >= STRIPE_W'(DRIVES)) ? rot_rem0 - STRIPE_W'(DRIVES)
                                                       : rot_rem0;

    r5spw_ram #(.WIDTH(BYTE_W), .DEPTH(DATA_BYTES)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_fill[POS_W-1:0]),
        .i_wdata (i_in.data_byte),
        .i_re    (b_re),
        .i_raddr (r_pos[POS_W-1:0]),
        .o_rdata (b_rdata)
    );

    r5spw_ram #(.WIDTH(BYTE_W), .DEPTH(BLOCK_BYTES)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (r_wb_v),
        .i_waddr (r_wb_addr),
        .i_wdata (pw_data),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FILL:  if (flush_now) n_state = S_WB;
            S_WB:    n_state = S_QUOT;
            S_QUOT:  n_state = S_ROT;
            S_ROT:   n_state = S_EMIT;
            S_EMIT:  if (issue && last_issue) n_state = S_DRAIN;
            S_DRAIN: if (!r_s1_v || advance) n_state = S_FILL;
            default: n_state = S_FILL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_first  <= '0;
            r_cnt    <= '0;
            r_fill   <= '0;
            r_poff   <= '0;
            r_pvalid <= '0;
            r_wb_v   <= 1'b0;
            r_fwd    <= 1'b0;
            r_s1_v   <= 1'b0;
            r_o_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_first <= i_cfg_wdata;
            end

            r_wb_v <= accept;
            r_fwd  <= accept && r_wb_v && (r_wb_addr == r_poff);
            if (r_wb_v) begin
                r_pvalid[r_wb_addr] <= 1'b1;
            end
            if (accept) begin
                r_fill <= fill_inc;
                r_poff <= (r_poff == OFF_W'(BLOCK_BYTES - 1)) ? '0 : r_poff + OFF_W'(1);
            end

            if (issue) begin
                r_s1_v <= 1'b1;
            end else if (advance) begin
                r_s1_v <= 1'b0;
            end
            if (advance) begin
                r_o_v <= r_s1_v;
            end

            if (r_state == S_DRAIN && n_state == S_FILL) begin
                r_fill   <= '0;
                r_poff   <= '0;
                r_pvalid <= '0;
                r_cnt    <= r_cnt + STRIPE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wb_addr <= r_poff;
            r_wb_byte <= i_in.data_byte;
        end
        r_fwd_data <= pw_data;

        case (r_state)
            S_WB:    r_stripe <= r_first + r_cnt;
            S_QUOT:  r_q <= STRIPE_W'(rot_prod >> ROT_SH);
            S_ROT: begin
                r_pdrive <= DRIVE_W'(DRIVES - 1) - DRIVE_W'(rot_rem);
                r_d      <= '0;
                r_b      <= '0;
                r_pos    <= '0;
            end
            default: ;
        endcase

        if (issue) begin
            r_s1_drive <= r_d;
            r_s1_off   <= r_b;
            r_s1_par   <= is_par;
            r_s1_last  <= last_issue;
            r_s1_zero  <= is_par ? !r_pvalid[r_b] : (r_pos >= r_fill);
            if (!is_par) begin
                r_pos <= r_pos + FILL_W'(1);
            end
            if (r_b == OFF_W'(BLOCK_BYTES - 1)) begin
                r_b <= '0;
                r_d <= r_d + DRIVE_W'(1);
            end else begin
                r_b <= r_b + OFF_W'(1);
            end
        end

        if (advance && r_s1_v) begin
            r_o_drive  <= r_s1_drive;
            r_o_off    <= r_s1_off;
            r_o_par    <= r_s1_par;
            r_o_last   <= r_s1_last;
            r_o_stripe <= r_stripe;
            r_o_byte   <= r_s1_zero ? '0 : (r_s1_par ? p_rdata : b_rdata);
        end
    end

    assign o_out.valid         = r_o_v;
    assign o_out.drive_index   = DRV_FIELD_W'(r_o_drive);
    assign o_out.stripe_number = r_o_stripe;
    assign o_out.byte_offset   = OFF_FIELD_W'(r_o_off);
    assign o_out.out_byte      = r_o_byte;
    assign o_out.is_parity     = r_o_par;
    assign o_out.run_last      = r_o_last;
endmodule
